// ===== design/ttoi_pkg.sv =====
// Shared types, constants and helper functions for the text-to-integer converter.
`timescale 1ns / 1ps
`default_nettype none

package ttoi_pkg;

  // Storage for digit characters is always four 64-bit words of eight bytes.
  localparam int NumChars     = 32;
  localparam int CharsPerWord = 8;
  localparam int CharW        = 8;
  localparam int CfgDataW     = CharsPerWord * CharW;
  localparam int CfgIdxW      = 3;
  localparam int LenW         = 6;
  localparam int IdxW         = $clog2(NumChars);
  localparam int MaxBase      = 32;
  localparam int ValueWidth   = 32;
  localparam int OutW         = 32;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;
  localparam logic [CharW-1:0] CharPlus  = 8'h2B;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;
  localparam logic [CharW-1:0] CharDig0  = 8'h30;
  localparam logic [CharW-1:0] CharDig9  = 8'h39;
  localparam logic [CharW-1:0] CharUpA   = 8'h41;
  localparam logic [CharW-1:0] CharUpZ   = 8'h5A;
  localparam logic [CharW-1:0] CharLoA   = 8'h61;
  localparam logic [CharW-1:0] CharLoZ   = 8'h7A;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBaseChars0 = 3'd0,
    CfgBaseChars1 = 3'd1,
    CfgBaseChars2 = 3'd2,
    CfgBaseChars3 = 3'd3,
    CfgBaseLength = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhSpace = 2'd0,
    PhSign  = 2'd1,
    PhDigit = 2'd2,
    PhDone  = 2'd3
  } phase_e;

  typedef logic [NumChars-1:0][CharW-1:0] base_chars_t;

  // Classification of one incoming character, made as it is accepted.
  typedef struct packed {
    logic            is_space;
    logic            is_plus;
    logic            is_minus;
    logic            is_digit;
    logic [IdxW-1:0] digit;
  } char_class_t;

  function automatic logic is_alnum(input logic [CharW-1:0] c);
    return ((c >= CharDig0) && (c <= CharDig9)) ||
           ((c >= CharUpA) && (c <= CharUpZ)) ||
           ((c >= CharLoA) && (c <= CharLoZ));
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  // Radix actually used for lookup and accumulation.
  function automatic logic [LenW-1:0] used_len(input logic [LenW-1:0] len);
    return (len > LenW'(MaxBase)) ? LenW'(MaxBase) : len;
  endfunction

endpackage

`default_nettype wire

// ===== design/ttoi_decode.sv =====
// Character classifier: whitespace, sign and parallel digit lookup against the base.
`timescale 1ns / 1ps
`default_nettype none

module ttoi_decode (
  input  wire ttoi_pkg::base_chars_t          chars_i,
  input  wire logic [ttoi_pkg::LenW-1:0]      len_i,
  input  wire logic [ttoi_pkg::CharW-1:0]     char_i,
  output ttoi_pkg::char_class_t               class_o
);

  logic [ttoi_pkg::LenW-1:0] len_used;

  assign len_used = ttoi_pkg::used_len(len_i);

  always_comb begin
    class_o          = '0;
    class_o.is_space = ttoi_pkg::is_space(char_i);
    class_o.is_plus  = (char_i == ttoi_pkg::CharPlus);
    class_o.is_minus = (char_i == ttoi_pkg::CharMinus);
    // Walk downwards so that the lowest matching position wins.
    for (int i = ttoi_pkg::NumChars - 1; i >= 0; i--) begin
      if ((ttoi_pkg::LenW'(i) < len_used) && (chars_i[i] == char_i)) begin
        class_o.is_digit = 1'b1;
        class_o.digit    = ttoi_pkg::IdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/ttoi_base_check.sv =====
// Registered validity check of the configured base: radix range, alphanumerics, no repeats.
`timescale 1ns / 1ps
`default_nettype none

module ttoi_base_check (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ttoi_pkg::base_chars_t      chars_i,
  input  wire logic [ttoi_pkg::LenW-1:0]  len_i,
  output logic                            base_ok_o
);

  logic ok_d;
  logic ok_q;

  always_comb begin
    ok_d = (len_i >= ttoi_pkg::LenW'(2)) && (len_i <= ttoi_pkg::LenW'(ttoi_pkg::MaxBase));
    for (int i = 0; i < ttoi_pkg::NumChars; i++) begin
      if (ttoi_pkg::LenW'(i) < len_i) begin
        if (!ttoi_pkg::is_alnum(chars_i[i])) begin
          ok_d = 1'b0;
        end
        for (int j = i + 1; j < ttoi_pkg::NumChars; j++) begin
          if ((ttoi_pkg::LenW'(j) < len_i) && (chars_i[j] == chars_i[i])) begin
            ok_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else begin
      ok_q <= ok_d;
    end
  end

  assign base_ok_o = ok_q;

endmodule

`default_nettype wire

// ===== design/ttoi_core.sv =====
// Input register, parse state machine with multiply-add accumulator, and result register.
`timescale 1ns / 1ps
`default_nettype none

module ttoi_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire ttoi_pkg::char_class_t           class_i,
  input  wire logic                            last_i,
  input  wire logic [ttoi_pkg::LenW-1:0]       len_i,
  input  wire logic                            base_ok_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [ttoi_pkg::OutW-1:0]     value_o,
  output logic                                 base_ok_o
);

  logic                             in_v_q;
  ttoi_pkg::char_class_t            cls_q;
  logic                             last_q;
  logic                             accept_in;
  logic                             proc;

  ttoi_pkg::phase_e                 phase_q, phase_d, ph_cur;
  logic                             neg_q, neg_d;
  logic [ttoi_pkg::ValueWidth-1:0]  acc_q, acc_d;
  logic [ttoi_pkg::ValueWidth+ttoi_pkg::LenW-1:0] prod;
  logic [ttoi_pkg::ValueWidth-1:0]  acc_mac;
  logic [ttoi_pkg::ValueWidth-1:0]  res;

  logic                             out_v_q;
  logic signed [ttoi_pkg::OutW-1:0] value_q, value_d;
  logic                             ok_q;

  // A character without a result always moves on; the last one needs a free result slot.
  assign proc       = in_v_q && (!last_q || !out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !proc;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign prod    = acc_q * ttoi_pkg::used_len(len_i);
  assign acc_mac = prod[ttoi_pkg::ValueWidth-1:0] +
                   ttoi_pkg::ValueWidth'(cls_q.digit);

  always_comb begin
    ph_cur  = phase_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    // Leaving the whitespace run falls straight through into sign handling.
    if ((phase_q == ttoi_pkg::PhSpace) && !cls_q.is_space) begin
      ph_cur = ttoi_pkg::PhSign;
    end
    unique case (ph_cur)
      ttoi_pkg::PhSpace: begin
        phase_d = ttoi_pkg::PhSpace;
      end
      ttoi_pkg::PhSign: begin
        if (cls_q.is_minus) begin
          neg_d   = !neg_q;
          phase_d = ttoi_pkg::PhSign;
        end else if (cls_q.is_plus) begin
          phase_d = ttoi_pkg::PhSign;
        end else if (cls_q.is_digit) begin
          acc_d   = acc_mac;
          phase_d = ttoi_pkg::PhDigit;
        end else begin
          phase_d = ttoi_pkg::PhDone;
        end
      end
      ttoi_pkg::PhDigit: begin
        if (cls_q.is_digit) begin
          acc_d   = acc_mac;
          phase_d = ttoi_pkg::PhDigit;
        end else begin
          phase_d = ttoi_pkg::PhDone;
        end
      end
      ttoi_pkg::PhDone: begin
        phase_d = ttoi_pkg::PhDone;
      end
      default: begin
        phase_d = ttoi_pkg::PhDone;
      end
    endcase
    res     = neg_d ? (~acc_d + ttoi_pkg::ValueWidth'(1)) : acc_d;
    value_d = base_ok_i ? ttoi_pkg::OutW'($signed(res)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (accept_in) begin
      in_v_q <= 1'b1;
    end else if (proc) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cls_q  <= class_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ttoi_pkg::PhSpace;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (proc) begin
      if (last_q) begin
        phase_q <= ttoi_pkg::PhSpace;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (proc && last_q) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      value_q <= value_d;
      ok_q    <= base_ok_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign value_o     = value_q;
  assign base_ok_o   = ok_q;

  a_invalid_base_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !ok_q) |-> (value_q == '0))
    else $error("result with a rejected base carries a non-zero value");

  a_state_cleared_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_q) |=> (phase_q == ttoi_pkg::PhSpace && !neg_q && acc_q == '0))
    else $error("parse state not cleared after the final character");

  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_v_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  a_digits_never_rewind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !last_q && phase_q == ttoi_pkg::PhDigit) |=>
      (phase_q == ttoi_pkg::PhDigit || phase_q == ttoi_pkg::PhDone))
    else $error("phase went back from the digit run within a string");

endmodule

`default_nettype wire

// ===== design/text_to_integer_any_base_unit.sv =====
// Top level: configuration registers, character classifier, base check and conversion core.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_stall_o    char_code_i, last_char_i
//   result    out        out_valid_o / out_stall_i  value_o, base_ok_o
//   config    in         cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One character per cycle is taken while in_stall_o is low; the accumulator loop is a single
// multiply-add per cycle. The final character is registered, then its result is registered.
// Reset clears the base registers, so the base reads as invalid until it is written.
// A stalled result blocks the next final character; input flows until that character waits.
`timescale 1ns / 1ps
`default_nettype none

module text_to_integer_any_base_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ttoi_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [ttoi_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [ttoi_pkg::CharW-1:0]         char_code_i,
  input  wire logic                               last_char_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [ttoi_pkg::OutW-1:0]        value_o,
  output logic                                    base_ok_o
);

  ttoi_pkg::base_chars_t          chars_q;
  logic [ttoi_pkg::LenW-1:0]      len_q;
  ttoi_pkg::char_class_t          cls;
  logic                           base_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q <= '0;
      len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttoi_pkg::CfgBaseChars0: chars_q[7:0]   <= cfg_wdata_i;
        ttoi_pkg::CfgBaseChars1: chars_q[15:8]  <= cfg_wdata_i;
        ttoi_pkg::CfgBaseChars2: chars_q[23:16] <= cfg_wdata_i;
        ttoi_pkg::CfgBaseChars3: chars_q[31:24] <= cfg_wdata_i;
        ttoi_pkg::CfgBaseLength: len_q <= cfg_wdata_i[ttoi_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  ttoi_decode u_decode (
    .chars_i (chars_q),
    .len_i   (len_q),
    .char_i  (char_code_i),
    .class_o (cls)
  );

  ttoi_base_check u_base_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .chars_i   (chars_q),
    .len_i     (len_q),
    .base_ok_o (base_ok)
  );

  ttoi_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .class_i     (cls),
    .last_i      (last_char_i),
    .len_i       (len_q),
    .base_ok_i   (base_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .base_ok_o   (base_ok_o)
  );

endmodule

`default_nettype wire
